[src/fpr_pkg.sv]
// Shared constants and types for the FIFO page replacement block.
package fpr_pkg;

    // Frame store sizing
    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;

    // Widths of the stored page, slot index and fill count
    localparam int PW     = (PAGE_BITS < 16) ? PAGE_BITS : 16;
    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FILL_W = $clog2(MAX_FRAMES + 1);
    // common width for comparing the fill count against the register
    localparam int CW     = (FILL_W > 4) ? FILL_W : 4;

    localparam logic [15:0] FAULT_MAX = 16'hFFFF;

    // Register map
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_ref;   // update frame state with the accepted word
        logic load_out;   // capture the result into the output register
    } t_dp_cmd;

endpackage

[src/fpr_ctrl.sv]
// Handshake controller: tracks the output register and issues datapath commands.
module fpr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output fpr_pkg::t_dp_cmd o_cmd
);
    import fpr_pkg::*;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    // Input is taken when the output register is free or being drained
    assign o_s_tready = (r_state == ST_EMPTY) || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == ST_FULL);

    assign o_cmd.take_ref = accept;
    assign o_cmd.load_out = accept;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EMPTY: begin
                if (accept) n_state = ST_FULL;
            end
            ST_FULL: begin
                if (!accept && i_m_tready) n_state = ST_EMPTY;
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/fpr_datapath.sv]
// Frame store, lookup, replacement pointer, fault counter and result register.
module fpr_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fpr_pkg::t_dp_cmd i_cmd,
    input  logic [3:0]       i_frames_in_use,
    input  logic [15:0]      i_page,
    input  logic             i_last,
    output logic             o_hit,
    output logic [2:0]       o_frame_slot,
    output logic             o_evicted_valid,
    output logic [15:0]      o_evicted_page,
    output logic [15:0]      o_fault_count
);
    import fpr_pkg::*;

    logic [PW-1:0]     r_pages [MAX_FRAMES];
    logic [FILL_W-1:0] r_filled, n_filled;
    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [15:0]       r_fault, n_fault;

    logic              r_hit, r_ev_valid;
    logic [2:0]        r_slot;
    logic [15:0]       r_ev_page, r_fault_out;

    logic [PW-1:0]     page;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot, slot, slot_inc;
    logic [CW-1:0]     cfg_w, usable, filled_w, oldest_w;
    logic              ev_valid, do_write;
    logic [PW-1:0]     ev_page;
    logic [31:0]       slot32, ev32;

    assign page = i_page[PW-1:0];

    // Usable frame count: zero acts as one, clamp at the store size
    always_comb begin
        cfg_w = CW'(i_frames_in_use);
        if (cfg_w == '0)
            usable = CW'(1);
        else if (cfg_w > CW'(MAX_FRAMES))
            usable = CW'(MAX_FRAMES);
        else
            usable = cfg_w;
    end

    assign filled_w = CW'(r_filled);
    assign oldest_w = CW'(r_oldest);

    // Parallel compare over the filled frames, lowest match wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (!hit && (FILL_W'(i) < r_filled) && (r_pages[i] == page)) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    // Miss handling: fill next empty frame, else replace at the oldest pointer
    always_comb begin
        slot     = hit_slot;
        n_filled = r_filled;
        n_oldest = r_oldest;
        ev_valid = 1'b0;
        ev_page  = '0;
        do_write = 1'b0;
        slot_inc = '0;
        n_fault  = r_fault;
        if (!hit) begin
            do_write = 1'b1;
            if (filled_w < usable) begin
                slot     = r_filled[SLOT_W-1:0];
                n_filled = r_filled + FILL_W'(1);
            end else begin
                slot     = (oldest_w < usable) ? r_oldest : '0;
                ev_valid = 1'b1;
                ev_page  = r_pages[slot];
                slot_inc = slot + SLOT_W'(1);
                n_oldest = ((CW'(slot) + CW'(1)) >= usable) ? '0 : slot_inc;
            end
            if (r_fault != FAULT_MAX) n_fault = r_fault + 16'd1;
        end
    end

    assign slot32 = 32'(slot);
    assign ev32   = 32'(ev_page);

    // Sequence state; a last reference clears it after its result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_oldest <= '0;
            r_fault  <= '0;
        end else if (i_cmd.take_ref) begin
            if (i_last) begin
                r_filled <= '0;
                r_oldest <= '0;
                r_fault  <= '0;
            end else begin
                r_filled <= n_filled;
                r_oldest <= n_oldest;
                r_fault  <= n_fault;
            end
        end
    end

    // Frame store write; stale contents are masked by the fill count
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_ref && do_write) r_pages[slot] <= page;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_hit       <= hit;
            r_slot      <= slot32[2:0];
            r_ev_valid  <= ev_valid;
            r_ev_page   <= ev32[15:0];
            r_fault_out <= n_fault;
        end
    end

    assign o_hit           = r_hit;
    assign o_frame_slot    = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_count   = r_fault_out;

    // Fill count never runs past the store
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FILL_W'(MAX_FRAMES))
        else $error("fill count beyond frame store");

    // Last reference empties the sequence
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_ref && i_last) |=> (r_filled == '0 && r_fault == '0 && r_oldest == '0))
        else $error("sequence not cleared after last reference");

    // A fault below saturation bumps the counter by one
    a_fault_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_ref && !i_last && !hit && r_fault != FAULT_MAX)
        |=> (r_fault == $past(r_fault) + 16'd1))
        else $error("fault counter did not advance");

    // A hit leaves the fill count and pointer alone
    a_hit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_ref && !i_last && hit)
        |=> ($stable(r_filled) && $stable(r_oldest) && $stable(r_fault)))
        else $error("hit changed replacement state");

endmodule

[src/fifo_page_replacement_top.sv]
// Top level of the FIFO page replacement block: ports, config register, wiring.
// Each input word carries one page reference; the block compares it against every
// filled frame, fills or replaces a frame on a fault, and returns one result word.
// A reference's lookup over all frames and the pointer update are combinational,
// settling between the frame registers and the output register, so a new word
// is taken every cycle while the downstream side keeps taking results.
// When a result sits unread, input stalls until it is taken. A word with tlast set
// empties the frames, pointer and fault count after its own result. The
// frames_in_use register sits at byte address 0 and should be written while idle.
module fifo_page_replacement_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] page
    input  logic        i_s_tlast,   // last_in_sequence
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [2:0] frame_slot, [18:3] evicted_page,
                                     // [34:19] fault_count, [39:35] zero
    output logic [1:0]  o_m_tuser,   // [0] hit, [1] evicted_valid
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import fpr_pkg::*;

    t_dp_cmd     cmd;
    logic [3:0]  r_frames_in_use;
    logic        sel_reg;
    logic        hit, ev_valid;
    logic [2:0]  frame_slot;
    logic [15:0] ev_page, fault_count;

    // Config register
    assign o_pready = 1'b1;
    assign sel_reg  = (i_paddr[2] == REG_FRAMES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= 4'd3;
        end else if (i_psel && i_penable && i_pwrite && sel_reg) begin
            r_frames_in_use <= i_pwdata[3:0];
        end
    end

    assign o_prdata = sel_reg ? {28'd0, r_frames_in_use} : 32'd0;

    fpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    fpr_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_frames_in_use (r_frames_in_use),
        .i_page          (i_s_tdata),
        .i_last          (i_s_tlast),
        .o_hit           (hit),
        .o_frame_slot    (frame_slot),
        .o_evicted_valid (ev_valid),
        .o_evicted_page  (ev_page),
        .o_fault_count   (fault_count)
    );

    // Result packing
    assign o_m_tdata = {5'd0, fault_count, ev_page, frame_slot};
    assign o_m_tuser = {ev_valid, hit};

endmodule
